### rtl/matrix_vector_dot_product_macros.svh
// Assertion macros used by the checker of this block.
`ifndef MATRIX_VECTOR_DOT_PRODUCT_MACROS_SVH
`define MATRIX_VECTOR_DOT_PRODUCT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define MVDP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define MVDP_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/mvdp_pkg.sv
`default_nettype none

package mvdp_pkg;

    localparam int OPCODE_W = 2;
    localparam int ROW_W    = 8;
    localparam int COL_W    = 6;
    localparam int DATA_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int LOGIT_W  = 38;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE_WEIGHT = 2'd0,
        OP_WRITE_ACT    = 2'd1,
        OP_COMPUTE      = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } mac_ctrl_t;

endpackage

`default_nettype wire

### rtl/matrix_vector_dot_product.sv
// Channel   Handshake             Payload
// in        in_valid / in_stall   opcode, row_index, column_index, value
// out       out_valid / out_stall logit, result_row
// cfg       cfg_write_en          cfg_write_data (columns in use)
//
// A compute request turns the activation ring of COLS cells once, with one weight
// read and one multiply-accumulate per cell position in use, then two MAC stages
// drain.
// in_stall is high from a compute request until its result enters the output register.
// Reset clears control state only; weight memory and activation cells are undefined.
`default_nettype none

module matrix_vector_dot_product #(
    parameter int ROWS = 256,
    parameter int COLS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic        [mvdp_pkg::CFG_W-1:0]   cfg_write_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic        [mvdp_pkg::OPCODE_W-1:0] opcode,
    input  wire logic        [mvdp_pkg::ROW_W-1:0]   row_index,
    input  wire logic        [mvdp_pkg::COL_W-1:0]   column_index,
    input  wire logic signed [mvdp_pkg::DATA_W-1:0]  value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed      [mvdp_pkg::LOGIT_W-1:0] logit,
    output logic             [mvdp_pkg::ROW_W-1:0]   result_row
);

    localparam int MEM_DEPTH = ROWS * COLS;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W     = $clog2(COLS + 1);

    mvdp_pkg::state_t state_reg;
    mvdp_pkg::state_t state_next;

    logic [mvdp_pkg::CFG_W-1:0]          cols_reg;
    logic [CNT_W-1:0]                    k_reg;
    logic [CNT_W-1:0]                    k_next;
    logic [MEM_AW-1:0]                   addr_reg;
    logic [MEM_AW-1:0]                   addr_next;
    logic                                row_ok_reg;
    logic [mvdp_pkg::ROW_W-1:0]          row_hold_reg;
    logic                                step_v_reg;
    logic                                step_last_reg;
    logic signed [mvdp_pkg::DATA_W-1:0]  w_q_reg;
    logic signed [mvdp_pkg::DATA_W-1:0]  a_q_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [mvdp_pkg::LOGIT_W-1:0] logit_reg;
    logic [mvdp_pkg::ROW_W-1:0]          result_row_reg;

    logic                                accept;
    logic                                row_in_range;
    logic                                col_in_range;
    logic                                wmem_we;
    logic                                act_we;
    logic                                start;
    logic                                running;
    logic                                load_out;
    logic                                out_free;
    logic [MEM_AW-1:0]                   wr_addr;
    logic [MEM_AW-1:0]                   base_addr;
    logic                                mac_done;
    logic signed [mvdp_pkg::LOGIT_W-1:0] mac_acc;
    mvdp_pkg::mac_ctrl_t                 mac_ctrl;

    logic signed [mvdp_pkg::DATA_W-1:0]  wmem [MEM_DEPTH];
    logic signed [mvdp_pkg::DATA_W-1:0]  cell_q [COLS];

    assign in_stall     = (state_reg != mvdp_pkg::ST_IDLE);
    assign accept       = in_valid && !in_stall;
    assign row_in_range = 32'(row_index) < 32'(ROWS);
    assign col_in_range = 32'(column_index) < 32'(COLS);
    assign base_addr    = MEM_AW'(32'(row_index) * 32'(COLS));
    assign wr_addr      = MEM_AW'(32'(row_index) * 32'(COLS) + 32'(column_index));
    assign out_free     = !out_valid_reg || !out_stall;

    always_comb
    begin
        wmem_we = 1'b0;
        act_we  = 1'b0;
        start   = 1'b0;
        if (accept)
        begin
            case (opcode)
                mvdp_pkg::OP_WRITE_WEIGHT: wmem_we = row_in_range && col_in_range;
                mvdp_pkg::OP_WRITE_ACT:    act_we  = col_in_range;
                mvdp_pkg::OP_COMPUTE:      start   = 1'b1;
                default:                   start   = 1'b0;
            endcase
        end
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        addr_next  = addr_reg;
        running    = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            mvdp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mvdp_pkg::ST_RUN;
                    k_next     = '0;
                    addr_next  = base_addr;
                end
            end
            mvdp_pkg::ST_RUN:
            begin
                running   = 1'b1;
                k_next    = k_reg + 1'b1;
                addr_next = addr_reg + 1'b1;
                if (k_reg == CNT_W'(COLS - 1))
                begin
                    state_next = mvdp_pkg::ST_DRAIN;
                end
            end
            mvdp_pkg::ST_DRAIN:
            begin
                if (mac_done)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = mvdp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mvdp_pkg::ST_HOLD;
                    end
                end
            end
            mvdp_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = mvdp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mvdp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mvdp_pkg::ST_IDLE;
            cols_reg      <= mvdp_pkg::CFG_RESET;
            k_reg         <= '0;
            addr_reg      <= '0;
            row_ok_reg    <= 1'b0;
            step_v_reg    <= 1'b0;
            step_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            step_v_reg    <= running && row_ok_reg
                             && (mvdp_pkg::CFG_W'(k_reg) < cols_reg);
            step_last_reg <= running && (k_reg == CNT_W'(COLS - 1));
            if (cfg_write_en)
            begin
                cols_reg <= cfg_write_data;
            end
            if (start)
            begin
                row_ok_reg <= row_in_range;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_hold_reg <= row_index;
        end
        if (load_out)
        begin
            logit_reg      <= mac_acc;
            result_row_reg <= row_hold_reg;
        end
        a_q_reg <= cell_q[0];
    end

    // weight memory, registered read
    always_ff @(posedge clk)
    begin
        if (wmem_we)
        begin
            wmem[wr_addr] <= value;
        end
        w_q_reg <= wmem[addr_reg];
    end

    // activation ring: cell i takes from cell i+1, the head feeds the MAC
    for (genvar i = 0; i < COLS; i++)
    begin : g_cell
        mvdp_cell u_cell (
            .clk        (clk),
            .load_en    (act_we && (32'(column_index) == i)),
            .load_value (value),
            .shift_en   (running),
            .shift_in   (cell_q[(i + 1) % COLS]),
            .q          (cell_q[i])
        );
    end

    assign mac_ctrl.clear = start;
    assign mac_ctrl.valid = step_v_reg;
    assign mac_ctrl.last  = step_last_reg;

    mvdp_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .weight (w_q_reg),
        .act    (a_q_reg),
        .acc    (mac_acc),
        .done   (mac_done)
    );

    assign out_valid  = out_valid_reg;
    assign logit      = logit_reg;
    assign result_row = result_row_reg;

endmodule

`default_nettype wire

### rtl/mvdp_cell.sv
`default_nettype none

module mvdp_cell (
    input  wire logic                               clk,
    input  wire logic                               load_en,
    input  wire logic signed [mvdp_pkg::DATA_W-1:0] load_value,
    input  wire logic                               shift_en,
    input  wire logic signed [mvdp_pkg::DATA_W-1:0] shift_in,
    output logic signed      [mvdp_pkg::DATA_W-1:0] q
);

    logic signed [mvdp_pkg::DATA_W-1:0] q_reg;
    logic signed [mvdp_pkg::DATA_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (load_en)
        begin
            q_next = load_value;
        end
        else if (shift_en)
        begin
            q_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

### rtl/mvdp_mac.sv
`default_nettype none

module mvdp_mac (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mvdp_pkg::mac_ctrl_t                 ctrl,
    input  wire logic signed [mvdp_pkg::DATA_W-1:0]  weight,
    input  wire logic signed [mvdp_pkg::DATA_W-1:0]  act,
    output logic signed      [mvdp_pkg::LOGIT_W-1:0] acc,
    output logic                                     done
);

    logic signed [mvdp_pkg::PROD_W-1:0]  prod_reg;
    logic                                pv_reg;
    logic                                plast_reg;
    logic signed [mvdp_pkg::LOGIT_W-1:0] acc_reg;
    logic signed [mvdp_pkg::LOGIT_W-1:0] acc_next;
    logic                                done_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= weight * act;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (pv_reg)
        begin
            acc_next = acc_reg + mvdp_pkg::LOGIT_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            pv_reg    <= ctrl.valid;
            plast_reg <= ctrl.last;
            done_reg  <= plast_reg;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### rtl/mvdp_checker.sv
`default_nettype none

`include "matrix_vector_dot_product_macros.svh"

module mvdp_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_valid,
    input wire logic                                 in_stall,
    input wire logic        [mvdp_pkg::OPCODE_W-1:0] opcode,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic signed [mvdp_pkg::LOGIT_W-1:0]  logit,
    input wire logic        [mvdp_pkg::ROW_W-1:0]    result_row
);

    logic in_take;
    logic compute_take;
    logic write_take;

    assign in_take      = in_valid && !in_stall;
    assign compute_take = in_take && (opcode == mvdp_pkg::OP_COMPUTE);
    assign write_take   = in_take && ((opcode == mvdp_pkg::OP_WRITE_WEIGHT)
                                      || (opcode == mvdp_pkg::OP_WRITE_ACT));

    `MVDP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(logit) && $stable(result_row), "stalled result changed")
    `MVDP_ASSERT_NEXT(a_busy_after_compute, clk, rst_n, compute_take, in_stall, "compute request did not make the block busy")
    `MVDP_ASSERT_NEXT(a_write_no_result, clk, rst_n, write_take && !out_valid, !out_valid, "write request produced a result")
    `MVDP_ASSERT_SAME(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall), "result appeared without a compute in flight")

endmodule

bind matrix_vector_dot_product mvdp_checker u_mvdp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .logit      (logit),
    .result_row (result_row)
);

`default_nettype wire

### sim/tb_matrix_vector_dot_product.sv
`default_nettype none

module tb_matrix_vector_dot_product;

    localparam int ROWS = 256;
    localparam int COLS = 64;
    localparam int DRAIN_CYCLES = COLS + 8;
    localparam int PHASES = 9;
    localparam logic [mvdp_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [mvdp_pkg::LOGIT_W-1:0] logit;
        logic [mvdp_pkg::ROW_W-1:0]          row;
    } row_logit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [mvdp_pkg::CFG_W-1:0] cfg_write_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [mvdp_pkg::OPCODE_W-1:0] opcode = '0;
    logic [mvdp_pkg::ROW_W-1:0] row_index = '0;
    logic [mvdp_pkg::COL_W-1:0] column_index = '0;
    logic signed [mvdp_pkg::DATA_W-1:0] value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [mvdp_pkg::LOGIT_W-1:0] logit;
    logic [mvdp_pkg::ROW_W-1:0] result_row;

    // shadow of the block state
    logic signed [mvdp_pkg::DATA_W-1:0] weight_mem [ROWS][COLS];
    logic signed [mvdp_pkg::DATA_W-1:0] act_mem [COLS];
    bit [COLS-1:0] weight_set [ROWS];
    bit [COLS-1:0] act_set;
    int unsigned cols_setting = 32'(mvdp_pkg::CFG_RESET);

    row_logit_t pending_logits [$];
    int unsigned fail_count = 0;
    int unsigned requests_sent = 0;
    int unsigned stall_left = 0;
    bit calm = 1'b0;

    matrix_vector_dot_product #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .row_index(row_index),
        .column_index(column_index),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .logit(logit),
        .result_row(result_row)
    );

    always #10 clk = ~clk;

    function automatic int unsigned active_cols();
        return (cols_setting > COLS) ? COLS : cols_setting;
    endfunction

    function automatic logic signed [mvdp_pkg::LOGIT_W-1:0] row_dot_product(
        input logic [mvdp_pkg::ROW_W-1:0] r);
        logic signed [mvdp_pkg::LOGIT_W-1:0] acc;
        acc = '0;
        for (int c = 0; c < active_cols(); c++)
        begin
            acc = acc + weight_mem[r][c] * act_mem[c];
        end
        return acc;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [mvdp_pkg::DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            return 16'sh8000;
        end
        if (r == 1)
        begin
            return 16'sh7FFF;
        end
        return mvdp_pkg::DATA_W'($urandom);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    task automatic send_request(input logic [mvdp_pkg::OPCODE_W-1:0] op,
                                input logic [mvdp_pkg::ROW_W-1:0] r,
                                input logic [mvdp_pkg::COL_W-1:0] c,
                                input logic signed [mvdp_pkg::DATA_W-1:0] v);
        int unsigned gap;
        in_valid <= 1'b1;
        opcode <= op;
        row_index <= r;
        column_index <= c;
        value <= v;
        do
        begin
            @(posedge clk);
        end
        while (in_stall !== 1'b0);
        case (op)
            mvdp_pkg::OP_WRITE_WEIGHT:
            begin
                weight_mem[r][c] = v;
                weight_set[r][c] = 1'b1;
            end
            mvdp_pkg::OP_WRITE_ACT:
            begin
                act_mem[c] = v;
                act_set[c] = 1'b1;
            end
            mvdp_pkg::OP_COMPUTE:
            begin
                pending_logits.push_back('{logit: row_dot_product(r), row: r});
            end
            default:
            begin
            end
        endcase
        if (op != OP_UNUSED)
        begin
            requests_sent++;
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_logits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_columns(input logic [mvdp_pkg::CFG_W-1:0] setting);
        wait_idle();
        cfg_write_en <= 1'b1;
        cfg_write_data <= setting;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cols_setting = 32'(setting);
    endtask

    // writes whatever the row still lacks, refreshes some entries, then computes
    task automatic fill_and_compute(input logic [mvdp_pkg::ROW_W-1:0] r);
        for (int c = 0; c < active_cols(); c++)
        begin
            if (!act_set[c] || $urandom_range(0, 5) == 0)
            begin
                send_request(mvdp_pkg::OP_WRITE_ACT, mvdp_pkg::ROW_W'($urandom),
                             mvdp_pkg::COL_W'(c), pick_value());
            end
            if (!weight_set[r][c] || $urandom_range(0, 5) == 0)
            begin
                send_request(mvdp_pkg::OP_WRITE_WEIGHT, r, mvdp_pkg::COL_W'(c), pick_value());
            end
        end
        if ($urandom_range(0, 39) == 0)
        begin
            wait_idle();
        end
        send_request(mvdp_pkg::OP_COMPUTE, r, mvdp_pkg::COL_W'($urandom),
                     mvdp_pkg::DATA_W'($urandom));
    endtask

    task automatic test_zero_columns();
        write_columns(7'd0);
        send_request(mvdp_pkg::OP_COMPUTE, 8'd0, 6'd0, 16'sh7FFF);
        send_request(mvdp_pkg::OP_COMPUTE, 8'd255, 6'd63, 16'sh8000);
    endtask

    task automatic test_extremes();
        write_columns(7'd2);
        send_request(mvdp_pkg::OP_WRITE_ACT, 8'd255, 6'd0, 16'sh8000);
        send_request(mvdp_pkg::OP_WRITE_ACT, 8'd0, 6'd1, 16'sh7FFF);
        send_request(mvdp_pkg::OP_WRITE_ACT, 8'd128, 6'd63, 16'sh8000);
        send_request(mvdp_pkg::OP_WRITE_WEIGHT, 8'd255, 6'd0, 16'sh8000);
        send_request(mvdp_pkg::OP_WRITE_WEIGHT, 8'd255, 6'd1, 16'sh8000);
        send_request(mvdp_pkg::OP_WRITE_WEIGHT, 8'd0, 6'd0, 16'sh7FFF);
        send_request(mvdp_pkg::OP_WRITE_WEIGHT, 8'd0, 6'd1, 16'sh7FFF);
        send_request(mvdp_pkg::OP_WRITE_WEIGHT, 8'd128, 6'd63, 16'sh7FFF);
        send_request(mvdp_pkg::OP_COMPUTE, 8'd255, 6'd0, 16'sh0000);
        send_request(mvdp_pkg::OP_COMPUTE, 8'd0, 6'd63, 16'shFFFF);
        write_columns(7'd1);
        send_request(mvdp_pkg::OP_COMPUTE, 8'd255, 6'd0, 16'sh1234);
        send_request(mvdp_pkg::OP_WRITE_WEIGHT, 8'd0, 6'd0, 16'sh0000);
        send_request(mvdp_pkg::OP_COMPUTE, 8'd0, 6'd0, 16'sh0000);
    endtask

    // unused opcode must leave weights and activations alone
    task automatic test_unused_opcode();
        send_request(OP_UNUSED, 8'd0, 6'd0, 16'sh5A5A);
        send_request(OP_UNUSED, 8'd255, 6'd63, 16'shA5A5);
        send_request(mvdp_pkg::OP_COMPUTE, 8'd0, 6'd0, 16'sh0000);
        send_request(mvdp_pkg::OP_COMPUTE, 8'd255, 6'd0, 16'sh0000);
    endtask

    task automatic test_random_traffic();
        int unsigned phase_cols [PHASES] = '{1, 3, 64, 127, 0, 8, 65, 2, 17};
        int unsigned phase_items [PHASES] = '{250, 250, 350, 200, 100, 300, 150, 150, 150};
        int unsigned target;
        int unsigned pick;
        int unsigned hot;
        for (int p = 0; p < PHASES; p++)
        begin
            write_columns(mvdp_pkg::CFG_W'(phase_cols[p]));
            target = requests_sent + phase_items[p];
            while (requests_sent < target)
            begin
                pick = $urandom_range(0, 99);
                hot = $urandom_range(0, 15);
                if (pick < 5)
                begin
                    send_request(OP_UNUSED, mvdp_pkg::ROW_W'($urandom),
                                 mvdp_pkg::COL_W'($urandom), mvdp_pkg::DATA_W'($urandom));
                end
                else if (pick < 15)
                begin
                    send_request($urandom_range(0, 1) ? mvdp_pkg::OP_WRITE_ACT
                                                      : mvdp_pkg::OP_WRITE_WEIGHT,
                                 mvdp_pkg::ROW_W'($urandom), mvdp_pkg::COL_W'($urandom),
                                 pick_value());
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    fill_and_compute(mvdp_pkg::ROW_W'($urandom));
                end
                else
                begin
                    fill_and_compute(mvdp_pkg::ROW_W'((hot < 8) ? hot : 240 + hot));
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        row_logit_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_logits.size() == 0)
            begin
                note_failure($sformatf("unexpected result: row %0d logit %0d",
                                       result_row, logit));
            end
            else
            begin
                want = pending_logits.pop_front();
                if (logit !== want.logit || result_row !== want.row)
                begin
                    note_failure($sformatf(
                        "mismatch: expected row %0d logit %0d, got row %0d logit %0d",
                        want.row, want.logit, result_row, logit));
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap();
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
            begin
                stall_left--;
            end
        end
    end

    // stretches without any idling on either side
    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
        begin
            calm <= ~calm;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_columns();
        test_extremes();
        test_unused_opcode();
        test_random_traffic();
        wait_idle();
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #24000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/mvdp_pkg.sv
rtl/mvdp_cell.sv
rtl/mvdp_mac.sv
rtl/matrix_vector_dot_product.sv
rtl/mvdp_checker.sv
sim/tb_matrix_vector_dot_product.sv
